// ===== rtl/ppid_pkg.sv =====
`default_nettype none

package ppid_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 31;

  // Fixed field widths
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned ILIM_W  = 31;
  localparam int unsigned OLIM_W  = 15;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned DRIVE_W = 16;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_KP   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KI   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KD   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ILIM = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_OLIM = 3'd4;

  // Reset values
  localparam logic [GAIN_W-1:0] KP_RST   = 16'd256;
  localparam logic [GAIN_W-1:0] KI_RST   = 16'd0;
  localparam logic [GAIN_W-1:0] KD_RST   = 16'd0;
  localparam logic [ILIM_W-1:0] ILIM_RST = 31'd10000;
  localparam logic [OLIM_W-1:0] OLIM_RST = 15'd10000;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [ILIM_W-1:0] ilim;
    logic [OLIM_W-1:0] olim;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/ppid_cfg.sv =====
`default_nettype none

module ppid_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ppid_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [ppid_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output ppid_pkg::cfg_t                       cfg_o
);

  ppid_pkg::cfg_t cfg_q;
  ppid_pkg::cfg_t cfg_d;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ppid_pkg::REG_KP:   cfg_d.kp   = cfg_wdata_i[ppid_pkg::GAIN_W-1:0];
        ppid_pkg::REG_KI:   cfg_d.ki   = cfg_wdata_i[ppid_pkg::GAIN_W-1:0];
        ppid_pkg::REG_KD:   cfg_d.kd   = cfg_wdata_i[ppid_pkg::GAIN_W-1:0];
        ppid_pkg::REG_ILIM: cfg_d.ilim = cfg_wdata_i[ppid_pkg::ILIM_W-1:0];
        ppid_pkg::REG_OLIM: cfg_d.olim = cfg_wdata_i[ppid_pkg::OLIM_W-1:0];
        default:            cfg_d      = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp   <= ppid_pkg::KP_RST;
      cfg_q.ki   <= ppid_pkg::KI_RST;
      cfg_q.kd   <= ppid_pkg::KD_RST;
      cfg_q.ilim <= ppid_pkg::ILIM_RST;
      cfg_q.olim <= ppid_pkg::OLIM_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/ppid_terms.sv =====
`default_nettype none

module ppid_terms #(
  parameter int unsigned DATA_WIDTH     = 16,
  parameter int unsigned GAIN_FRAC_BITS = 8,
  localparam int unsigned EW  = DATA_WIDTH + 1,
  localparam int unsigned PW  = EW + ppid_pkg::GAIN_W + 1,
  localparam int unsigned IW  = ppid_pkg::SUM_W + ppid_pkg::GAIN_W + 1,
  localparam int unsigned DPW = EW + ppid_pkg::GAIN_W + 2
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire ppid_pkg::cfg_t               cfg_i,
  input  wire logic                         valid_i,
  output logic                              ready_o,
  input  wire logic signed [DATA_WIDTH-1:0] setpoint_i,
  input  wire logic signed [DATA_WIDTH-1:0] measured_i,
  output logic                              valid_o,
  input  wire logic                         ready_i,
  output logic signed [PW-1:0]              p_o,
  output logic signed [IW-1:0]              i_o,
  output logic signed [DPW-1:0]             d_o,
  output logic                              ireset_o
);

  localparam int unsigned SW  = ppid_pkg::SUM_W;
  localparam int unsigned AW  = ((EW > SW) ? EW : SW) + 1;
  localparam int unsigned DFW = EW + 1;
  localparam int unsigned GW  = ppid_pkg::GAIN_W + 1;

  logic                  valid_q;
  logic signed [PW-1:0]  p_q;
  logic signed [IW-1:0]  i_q;
  logic signed [DPW-1:0] d_q;
  logic                  ireset_q;
  logic signed [SW-1:0]  error_sum_q, error_sum_d;
  logic signed [EW-1:0]  prev_err_q;

  logic                  take;
  logic signed [EW-1:0]  err;
  logic signed [AW-1:0]  sum_wide;
  logic                  sum_ovf;
  logic signed [SW-1:0]  sum_sat;
  logic signed [GW-1:0]  kp_s, ki_s, kd_s;
  logic signed [PW-1:0]  p_prod;
  logic signed [IW-1:0]  i_prod, i_term, ilim_s;
  logic                  i_over;
  logic signed [DFW-1:0] diff;
  logic signed [DPW-1:0] d_prod;

  assign ready_o = !valid_q || ready_i;
  assign take    = valid_i && ready_o;

  // Error and its change since the last sample
  assign err  = EW'(setpoint_i) - EW'(measured_i);
  assign diff = DFW'(err) - DFW'(prev_err_q);

  // Saturating running sum: overflow when the top bits disagree
  assign sum_wide = AW'(error_sum_q) + AW'(err);
  assign sum_ovf  = (sum_wide[AW-1:SW-1] != {(AW-SW+1){1'b0}}) &&
                    (sum_wide[AW-1:SW-1] != {(AW-SW+1){1'b1}});
  assign sum_sat  = sum_ovf ? {sum_wide[AW-1], {(SW-1){!sum_wide[AW-1]}}}
                            : sum_wide[SW-1:0];

  // Gains as positive signed operands
  assign kp_s = $signed({1'b0, cfg_i.kp});
  assign ki_s = $signed({1'b0, cfg_i.ki});
  assign kd_s = $signed({1'b0, cfg_i.kd});

  assign p_prod = PW'(kp_s) * PW'(err);
  assign i_prod = IW'(ki_s) * IW'(sum_sat);
  assign d_prod = DPW'(kd_s) * DPW'(diff);

  // Integral term with the limit check that resets the sum
  assign i_term = i_prod >>> GAIN_FRAC_BITS;
  assign ilim_s = $signed(IW'({1'b0, cfg_i.ilim}));
  assign i_over = (i_term > ilim_s) || (i_term < -ilim_s);

  assign error_sum_d = i_over ? '0 : sum_sat;

  // Advance state once per request, as it enters this stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      error_sum_q <= '0;
      prev_err_q  <= '0;
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (take) begin
        error_sum_q <= error_sum_d;
        prev_err_q  <= err;
      end
    end
  end

  // Hold the scaled terms for the summing stage
  always_ff @(posedge clk_i) begin
    if (take) begin
      p_q      <= p_prod >>> GAIN_FRAC_BITS;
      i_q      <= i_over ? '0 : i_term;
      d_q      <= d_prod >>> GAIN_FRAC_BITS;
      ireset_q <= i_over;
    end
  end

  assign valid_o  = valid_q;
  assign p_o      = p_q;
  assign i_o      = i_q;
  assign d_o      = d_q;
  assign ireset_o = ireset_q;

endmodule

`default_nettype wire

// ===== rtl/ppid_out.sv =====
`default_nettype none

module ppid_out #(
  parameter int unsigned PW  = 34,
  parameter int unsigned IW  = 49,
  parameter int unsigned DPW = 35
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic [ppid_pkg::OLIM_W-1:0]          olim_i,
  input  wire logic                                 valid_i,
  output logic                                      ready_o,
  input  wire logic signed [PW-1:0]                 p_i,
  input  wire logic signed [IW-1:0]                 i_i,
  input  wire logic signed [DPW-1:0]                d_i,
  input  wire logic                                 ireset_i,
  output logic                                      valid_o,
  input  wire logic                                 ready_i,
  output logic signed [ppid_pkg::DRIVE_W-1:0]       drive_o,
  output logic                                      integral_reset_o,
  output logic                                      saturated_o
);

  localparam int unsigned MW = (PW > IW) ? ((PW > DPW) ? PW : DPW)
                                         : ((IW > DPW) ? IW : DPW);
  localparam int unsigned TW = MW + 2;

  logic                                valid_q;
  logic signed [ppid_pkg::DRIVE_W-1:0] drive_q, drive_d;
  logic                                ireset_q;
  logic                                sat_q, sat_d;

  logic signed [TW-1:0] total;
  logic signed [TW-1:0] lim_s;
  logic                 take;

  assign ready_o = !valid_q || ready_i;
  assign take    = valid_i && ready_o;

  assign total = TW'(p_i) + TW'(i_i) + TW'(d_i);
  assign lim_s = $signed(TW'({1'b0, olim_i}));

  // Clamp to the symmetric output limit
  always_comb begin
    priority if (total > lim_s) begin
      drive_d = ppid_pkg::DRIVE_W'(lim_s);
      sat_d   = 1'b1;
    end else if (total < -lim_s) begin
      drive_d = ppid_pkg::DRIVE_W'(-lim_s);
      sat_d   = 1'b1;
    end else begin
      drive_d = total[ppid_pkg::DRIVE_W-1:0];
      sat_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk_i) begin
    if (take) begin
      drive_q  <= drive_d;
      ireset_q <= ireset_i;
      sat_q    <= sat_d;
    end
  end

  assign valid_o          = valid_q;
  assign drive_o          = drive_q;
  assign integral_reset_o = ireset_q;
  assign saturated_o      = sat_q;

endmodule

`default_nettype wire

// ===== rtl/positional_pid_controller.sv =====
// Channel   Direction  Handshake                 Payload
// in        sink       in_valid_i / in_ready_o    setpoint_i, measured_i
// out       source     out_valid_o / out_ready_i  drive_o, integral_reset_o, saturated_o
// cfg       sink       cfg_we_i                   cfg_addr_i, cfg_wdata_i
//
// One request per cycle sustained while out_ready_i holds; a result passes the input, terms and output registers.
// The error sum update, the integral multiply and its limit check are combinational
// in the terms stage, which sets the clock period.
// Reset clears all valid flags, the error sum, the previous error and loads register defaults.
// Each stage takes a new request whenever it is empty or its successor advances, so
// bubbles collapse and a stalled output backs up one stage at a time.
`default_nettype none

module positional_pid_controller #(
  parameter int unsigned DATA_WIDTH     = 16,
  parameter int unsigned GAIN_FRAC_BITS = 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ppid_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [ppid_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic signed [DATA_WIDTH-1:0]    setpoint_i,
  input  wire logic signed [DATA_WIDTH-1:0]    measured_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic signed [ppid_pkg::DRIVE_W-1:0]  drive_o,
  output logic                                 integral_reset_o,
  output logic                                 saturated_o
);

  localparam int unsigned EW  = DATA_WIDTH + 1;
  localparam int unsigned PW  = EW + ppid_pkg::GAIN_W + 1;
  localparam int unsigned IW  = ppid_pkg::SUM_W + ppid_pkg::GAIN_W + 1;
  localparam int unsigned DPW = EW + ppid_pkg::GAIN_W + 2;

  ppid_pkg::cfg_t cfg;

  logic                           in_valid_q;
  logic signed [DATA_WIDTH-1:0]   setpoint_q, measured_q;
  logic                           terms_ready;
  logic                           terms_valid;
  logic                           out_ready;
  logic signed [PW-1:0]           p_term;
  logic signed [IW-1:0]           i_term;
  logic signed [DPW-1:0]          d_term;
  logic                           ireset;

  ppid_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Input register
  assign in_ready_o = !in_valid_q || terms_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      setpoint_q <= setpoint_i;
      measured_q <= measured_i;
    end
  end

  ppid_terms #(
    .DATA_WIDTH     (DATA_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_terms (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .valid_i    (in_valid_q),
    .ready_o    (terms_ready),
    .setpoint_i (setpoint_q),
    .measured_i (measured_q),
    .valid_o    (terms_valid),
    .ready_i    (out_ready),
    .p_o        (p_term),
    .i_o        (i_term),
    .d_o        (d_term),
    .ireset_o   (ireset)
  );

  ppid_out #(
    .PW  (PW),
    .IW  (IW),
    .DPW (DPW)
  ) u_out (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .olim_i           (cfg.olim),
    .valid_i          (terms_valid),
    .ready_o          (out_ready),
    .p_i              (p_term),
    .i_i              (i_term),
    .d_i              (d_term),
    .ireset_i         (ireset),
    .valid_o          (out_valid_o),
    .ready_i          (out_ready_i),
    .drive_o          (drive_o),
    .integral_reset_o (integral_reset_o),
    .saturated_o      (saturated_o)
  );

endmodule

`default_nettype wire

// ===== rtl/ppid_checker.sv =====
`default_nettype none

module ppid_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_ready_o,
  input wire logic                                out_valid_o,
  input wire logic                                out_ready_i,
  input wire logic signed [ppid_pkg::DRIVE_W-1:0] drive_o,
  input wire logic                                integral_reset_o,
  input wire logic                                saturated_o
);

  // A stalled result keeps its flag and its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(drive_o) && $stable(integral_reset_o) && $stable(saturated_o))
    else $error("result changed while stalled");

  // The clamp is symmetric, so the most negative code never appears
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> drive_o != {1'b1, {(ppid_pkg::DRIVE_W-1){1'b0}}})
    else $error("drive outside symmetric range");

  // Input back-pressure only comes from a full output waiting to be taken
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with output free");

endmodule

bind positional_pid_controller ppid_checker u_ppid_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .drive_o          (drive_o),
  .integral_reset_o (integral_reset_o),
  .saturated_o      (saturated_o)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import ppid_pkg::*;

  localparam int     GAIN_FRAC   = 8;
  localparam longint SUM_MAX     = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_MIN     = -(longint'(1) <<< (SUM_W - 1));
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = REG_OLIM + 3'd1;
  localparam int     DRAIN_CYCLES = 8;
  localparam int     QUIET_LIMIT  = 1000;
  localparam int     HOLD_AT      = 200;
  localparam int     HOLD_CYCLES  = 60;
  localparam int     MAX_REPORTS  = 50;
  localparam int     PHASE_ITEMS  = 80;
  localparam int     SUM_STEPS    = 10;

  typedef struct packed {
    logic signed [15:0] sp;
    logic signed [15:0] ms;
  } sample_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      ireset;
    logic                      sat;
  } drive_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] setpoint_i = '0;
  logic signed [15:0] measured_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [DRIVE_W-1:0] drive_o;
  logic integral_reset_o;
  logic saturated_o;

  positional_pid_controller dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .setpoint_i      (setpoint_i),
    .measured_i      (measured_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .drive_o         (drive_o),
    .integral_reset_o(integral_reset_o),
    .saturated_o     (saturated_o)
  );

  sample_t       pending_samples[$];
  drive_result_t expected_drives[$];
  cfg_t          model_cfg;
  longint        err_sum;
  longint        prev_err;
  bit            idle_en = 1'b1;
  int unsigned   fail_count = 0;
  int unsigned   results_seen = 0;
  int unsigned   send_gap = 0;
  int unsigned   recv_gap = 0;
  int unsigned   hold_left = 0;
  bit            hold_done = 1'b0;
  int unsigned   quiet_cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Compute the controller output for one request and queue it
  function automatic void predict_drive(input logic signed [15:0] sp,
                                        input logic signed [15:0] ms);
    longint err, sum, p, i, d, drv, lim_i, lim_o;
    drive_result_t r;
    err   = longint'(sp) - longint'(ms);
    lim_i = longint'(model_cfg.ilim);
    lim_o = longint'(model_cfg.olim);
    r.ireset = 1'b0;
    r.sat    = 1'b0;

    // Accumulate error with saturation before forming the integral term
    sum = err_sum + err;
    if (sum > SUM_MAX) sum = SUM_MAX;
    if (sum < SUM_MIN) sum = SUM_MIN;
    err_sum = sum;

    p = (longint'(model_cfg.kp) * err) >>> GAIN_FRAC;
    i = (longint'(model_cfg.ki) * err_sum) >>> GAIN_FRAC;
    d = (longint'(model_cfg.kd) * (err - prev_err)) >>> GAIN_FRAC;

    // Drop the integral term and the sum when it runs past its limit
    if (i > lim_i || i < -lim_i) begin
      i = 0;
      err_sum = 0;
      r.ireset = 1'b1;
    end

    drv = p + i + d;
    if (drv > lim_o) begin
      drv = lim_o;
      r.sat = 1'b1;
    end else if (drv < -lim_o) begin
      drv = -lim_o;
      r.sat = 1'b1;
    end

    prev_err = err;
    r.drive = drv[DRIVE_W-1:0];
    expected_drives.push_back(r);
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 4))
      0: pick_gain = '0;
      1: pick_gain = '1;
      2: pick_gain = 16'd256;
      3: pick_gain = 16'($urandom_range(0, 1023));
      default: pick_gain = 16'($urandom);
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    case ($urandom_range(0, 3))
      0, 1: begin
        s.sp = 16'($urandom);
        s.ms = 16'($urandom);
      end
      2: begin
        s.ms = 16'($urandom);
        s.sp = s.ms + 16'($urandom_range(0, 600)) - 16'sd300;
      end
      default: begin
        s.sp = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        s.ms = $urandom_range(0, 1) ? 16'sh7fff : 16'(16'($urandom_range(0, 2)) - 1);
      end
    endcase
    return s;
  endfunction

  // Write one register and mirror it in the model; callers put junk into the bits above its width
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    case (idx)
      REG_KP:   model_cfg.kp   = value[GAIN_W-1:0];
      REG_KI:   model_cfg.ki   = value[GAIN_W-1:0];
      REG_KD:   model_cfg.kd   = value[GAIN_W-1:0];
      REG_ILIM: model_cfg.ilim = value[ILIM_W-1:0];
      REG_OLIM: model_cfg.olim = value[OLIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                                input logic [GAIN_W-1:0] kd, input logic [ILIM_W-1:0] ilim,
                                input logic [OLIM_W-1:0] olim);
    write_reg(REG_KP, {15'($urandom), kp});
    write_reg(REG_KI, {15'($urandom), ki});
    write_reg(REG_KD, {15'($urandom), kd});
    write_reg(REG_ILIM, ilim);
    write_reg(REG_OLIM, {16'($urandom), olim});
    // Unmapped index must leave every register alone
    write_reg(CFG_ADDR_W'($urandom_range(2 ** CFG_ADDR_W - 1, REG_UNUSED)), 31'($urandom));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold until every request is answered, then let the pipeline settle
  task automatic wait_idle();
    while (pending_samples.size() != 0 || expected_drives.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Request driver: offer queued samples, with random idle bursts between them while idle_en is set
  always @(posedge clk_i) begin
    bit nxt_valid;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      nxt_valid = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        predict_drive(setpoint_i, measured_i);
        void'(pending_samples.pop_front());
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (idle_en && $urandom_range(0, 3) == 0) begin
          send_gap = $urandom_range(0, 3);
        end else if (pending_samples.size() > 0) begin
          nxt_valid = 1'b1;
          setpoint_i <= pending_samples[0].sp;
          measured_i <= pending_samples[0].ms;
        end
      end
      in_valid_i <= nxt_valid;
    end
  end

  // Result monitor: compare against the oldest prediction, stall at random
  always @(posedge clk_i) begin
    bit nxt_ready;
    drive_result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_drives.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $error("unexpected result: drive %0d", drive_o);
        end else begin
          want = expected_drives.pop_front();
          if (drive_o !== want.drive) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $error("drive: expected %0d, got %0d", want.drive, drive_o);
          end
          if (integral_reset_o !== want.ireset) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $error("integral_reset: expected %0b, got %0b", want.ireset, integral_reset_o);
          end
          if (saturated_o !== want.sat) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $error("saturated: expected %0b, got %0b", want.sat, saturated_o);
          end
        end
      end

      // Hold off once for a long stretch so the pipeline backs up into the input
      if (results_seen == HOLD_AT && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        nxt_ready = 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        recv_gap = $urandom_range(0, 3);
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      out_ready_i <= nxt_ready;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int n;
    model_cfg.kp   = KP_RST;
    model_cfg.ki   = KI_RST;
    model_cfg.kd   = KD_RST;
    model_cfg.ilim = ILIM_RST;
    model_cfg.olim = OLIM_RST;
    err_sum  = 0;
    prev_err = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: input extremes and the output clamp boundary
    pending_samples.push_back('{16'sd0, 16'sd0});
    pending_samples.push_back('{16'sh7fff, 16'sh8000});
    pending_samples.push_back('{16'sh8000, 16'sh7fff});
    pending_samples.push_back('{16'sh7fff, 16'sh7fff});
    pending_samples.push_back('{16'sh8000, 16'sh8000});
    pending_samples.push_back('{16'sd10000, 16'sd0});
    pending_samples.push_back('{16'sd10001, 16'sd0});
    pending_samples.push_back('{16'sd0, 16'sd10000});
    pending_samples.push_back('{16'sd0, 16'sd10001});
    pending_samples.push_back('{-16'sd1, 16'sd0});
    pending_samples.push_back('{16'sd1, 16'sd0});
    pending_samples.push_back('{16'sd0, 16'sh8000});
    wait_idle();

    // Integral limit on both sides, exactly at the limit, and a large derivative
    apply_settings(16'd256, 16'd256, 16'hffff, 31'd1000, 15'h7fff);
    pending_samples.push_back('{16'sd500, 16'sd0});
    pending_samples.push_back('{16'sd600, 16'sd0});
    pending_samples.push_back('{16'sd0, 16'sd700});
    pending_samples.push_back('{16'sd0, 16'sd400});
    pending_samples.push_back('{16'sd1000, 16'sd0});
    pending_samples.push_back('{16'sh7fff, 16'sh8000});
    pending_samples.push_back('{16'sh8000, 16'sh7fff});
    pending_samples.push_back('{16'sd3, 16'sd0});
    wait_idle();

    // Random settings, extremes first
    for (int ph = 0; ph < 8; ph++) begin
      idle_en = (ph < 2) || ($urandom_range(0, 3) != 0);
      case (ph)
        0: apply_settings('1, '1, '1, '1, '1);
        1: apply_settings('0, '0, '0, '0, '0);
        default: begin
          case ($urandom_range(0, 3))
            0: n = 0;
            1: n = 32'h7fffffff;
            2: n = $urandom_range(0, 20000);
            default: n = $urandom;
          endcase
          apply_settings(pick_gain(), pick_gain(), pick_gain(), ILIM_W'(n),
                         $urandom_range(0, 2) == 0 ? 15'h7fff : OLIM_W'($urandom));
        end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) pending_samples.push_back(random_sample());
      wait_idle();
    end

    // Build a large positive error sum, then step the other way with a strong gain
    idle_en = 1'b0;
    apply_settings('0, 16'd1, '0, '1, '1);
    for (int k = 0; k < SUM_STEPS; k++) pending_samples.push_back('{16'sh7fff, 16'sh8000});
    wait_idle();
    apply_settings(16'd32768, 16'd1, '0, '1, '1);
    for (int k = 0; k < 20; k++) pending_samples.push_back('{16'sh8000, 16'sh7fff});
    wait_idle();

    // Clear the sum through the integral limit, then build it negative
    apply_settings('0, 16'd1, '0, '0, '1);
    pending_samples.push_back('{16'sd1, 16'sd0});
    wait_idle();
    apply_settings('0, 16'd1, '0, '1, '1);
    for (int k = 0; k < SUM_STEPS; k++) pending_samples.push_back('{16'sh8000, 16'sh7fff});
    wait_idle();
    apply_settings(16'd32768, 16'd1, '0, '1, '1);
    for (int k = 0; k < 20; k++) pending_samples.push_back('{16'sh7fff, 16'sh8000});
    wait_idle();

    // Closing stretch at full rate
    apply_settings(pick_gain(), pick_gain(), pick_gain(), 31'($urandom_range(0, 50000)),
                   OLIM_W'($urandom));
    for (int k = 0; k < 40; k++) pending_samples.push_back(random_sample());
    wait_idle();

    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
